[rtl/sld_pkg.sv]
// Shared types and constants for the stepped load generator.
// No dependencies; every other file except sld_div refers to this package by scoped names.
package sld_pkg;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TIMER = 2'd1;
    localparam logic [1:0] REQ_REPLY = 2'd2;

    localparam logic [1:0] GEN_INIT     = 2'd0;
    localparam logic [1:0] GEN_SENDING  = 2'd1;
    localparam logic [1:0] GEN_GATED    = 2'd2;
    localparam logic [1:0] GEN_DRAINING = 2'd3;

    localparam logic [2:0] REG_START_RATE     = 3'd0;
    localparam logic [2:0] REG_BACKLOG_MS     = 3'd1;
    localparam logic [2:0] REG_BURST_SIZE     = 3'd2;
    localparam logic [2:0] REG_STEP_DURATION  = 3'd3;
    localparam logic [2:0] REG_RATE_INCREMENT = 3'd4;
    localparam logic [2:0] REG_RATE_CEILING   = 3'd5;

    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [15:0] DEFAULT_MS   = 16'd1000;
    localparam logic [63:0] MAX31        = 64'h0000_0000_7FFF_FFFF;
    localparam logic [37:0] DELAY_MAX    = 38'h3F_FFFF_FFFF;
    localparam logic [9:0]  EMA_SCALE    = 10'd1000;
    localparam logic [6:0]  EMA_STEPS    = 7'd64;
    localparam logic [6:0]  GAP_STEPS    = 7'd38;

    typedef logic [29:0] limit_t;
    localparam limit_t DECADE_LIMIT [7] = '{
        30'd1000, 30'd10000, 30'd100000, 30'd1000000,
        30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [62:0] now;
        logic [62:0] sent_time;
    } req_t;

    typedef struct packed {
        logic [7:0]  send_count;
        logic        timer_armed;
        logic [37:0] timer_delay;
        logic [1:0]  gen_state;
        logic        done_res;
        logic [30:0] backlog_ema;
        logic [30:0] peak_backlog;
        logic [62:0] rtt_avg;
        logic [62:0] rtt_dev;
        logic [2:0]  bucket_index;
        logic [31:0] bucket_total;
        logic [31:0] outstanding;
    } rsp_t;

    typedef struct packed {
        logic [23:0] start_rate;
        logic [15:0] backlog_ms;
        logic [7:0]  burst_size;
        logic [62:0] step_duration;
        logic [23:0] rate_increment;
        logic [31:0] rate_ceiling;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic start_init;
        logic div_gap;
        logic gap_store;
        logic tick_a;
        logic div_ema;
        logic ema_store;
        logic tick_b;
        logic tick_c;
        logic reply_a;
        logic reply_b;
        logic reply_c;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] run_state;
        logic       div_done;
        logic       step_end;
        logic       drained;
        logic       out_free;
    } sts_t;

endpackage

[rtl/sld_cfg.sv]
// Configuration register file on the APB-style port.
// Depends on sld_pkg for the register indexes and the cfg_t type.
module sld_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output sld_pkg::cfg_t     cfg
);

    sld_pkg::cfg_t cfg_reg;
    logic [2:0]    index;

    assign index  = paddr[5:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_rate     <= 24'd1;
            cfg_reg.backlog_ms     <= sld_pkg::DEFAULT_MS;
            cfg_reg.burst_size     <= 8'd1;
            cfg_reg.step_duration  <= 63'(sld_pkg::NS_PER_SEC);
            cfg_reg.rate_increment <= 24'd0;
            cfg_reg.rate_ceiling   <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (index)
                sld_pkg::REG_START_RATE:     cfg_reg.start_rate     <= pwdata[23:0];
                sld_pkg::REG_BACKLOG_MS:     cfg_reg.backlog_ms     <= pwdata[15:0];
                sld_pkg::REG_BURST_SIZE:     cfg_reg.burst_size     <= pwdata[7:0];
                sld_pkg::REG_STEP_DURATION:  cfg_reg.step_duration  <= pwdata[62:0];
                sld_pkg::REG_RATE_INCREMENT: cfg_reg.rate_increment <= pwdata[23:0];
                sld_pkg::REG_RATE_CEILING:   cfg_reg.rate_ceiling   <= pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (index)
            sld_pkg::REG_START_RATE:     prdata = 64'(cfg_reg.start_rate);
            sld_pkg::REG_BACKLOG_MS:     prdata = 64'(cfg_reg.backlog_ms);
            sld_pkg::REG_BURST_SIZE:     prdata = 64'(cfg_reg.burst_size);
            sld_pkg::REG_STEP_DURATION:  prdata = 64'(cfg_reg.step_duration);
            sld_pkg::REG_RATE_INCREMENT: prdata = 64'(cfg_reg.rate_increment);
            sld_pkg::REG_RATE_CEILING:   prdata = 64'(cfg_reg.rate_ceiling);
            default:                     prdata = 64'd0;
        endcase
    end

endmodule

[rtl/sld_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Standalone; the dividend is presented left-aligned for the number of steps run.
module sld_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    input  logic [6:0]  steps,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [32:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] shifted;
    logic [33:0] trial;
    logic        fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[63]};
        trial   = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 33'd0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? trial[32:0] : shifted[32:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/sld_datapath.sv]
// Datapath: generator state, tick and reply arithmetic, histogram and result register.
// Depends on sld_pkg and instantiates the shared divider sld_div.
module sld_datapath #(
    parameter int CW = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  sld_pkg::cfg_t cfg,
    input  sld_pkg::req_t req,
    input  sld_pkg::cmd_t cmd,
    output sld_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sld_pkg::rsp_t rsp
);

    // Generator state.
    logic [1:0]    run_state_reg;
    logic [31:0]   rate_reg;
    logic [39:0]   gap_reg;
    logic [7:0]    burst_reg;
    logic [63:0]   step_begin_reg;
    logic [63:0]   last_sent_reg;
    logic [CW-1:0] sent_reg;
    logic [CW-1:0] recv_reg;
    logic [30:0]   peak_reg;
    logic [30:0]   ema_reg;
    logic [63:0]   rtt_avg_reg;
    logic [63:0]   rtt_dev_reg;
    logic [CW-1:0] hist_reg [8];

    // Per-item working registers.
    logic [1:0]    type_reg;
    logic [62:0]   now_reg;
    logic [62:0]   rq_reg;
    logic [30:0]   backlog_reg;
    logic [62:0]   prod_reg;
    logic [63:0]   next_reg;
    logic [63:0]   dly_reg;
    logic [62:0]   lat_reg;
    logic [63:0]   dev_reg;
    logic [7:0]    cnt_reg;
    logic          armed_reg;
    logic [37:0]   delay_reg;
    logic          done_reg;
    logic [2:0]    bidx_reg;
    logic [31:0]   btot_reg;

    logic          rsp_valid_reg;
    sld_pkg::rsp_t rsp_reg;

    // Effective configuration values.
    logic [31:0]   eff_rate;
    logic [7:0]    eff_burst;
    logic [15:0]   eff_ms;

    // Tick arithmetic.
    logic [CW-1:0] sent_inc;
    logic [CW-1:0] diff;
    logic [63:0]   diff_w;
    logic [30:0]   backlog;
    logic [62:0]   prod_calc;
    logic [47:0]   ema_lhs;
    logic [47:0]   rate_rhs;
    logic          sending;
    logic [63:0]   now_w;
    logic [63:0]   next_send;
    logic [63:0]   next_gate;
    logic          step_end;
    logic [32:0]   rate_sum;
    logic [31:0]   rate_new;
    logic          drain;
    logic [1:0]    state_after;

    // Reply arithmetic.
    logic [62:0]   lat_calc;
    logic [2:0]    bidx_calc;
    logic [63:0]   lat_w;
    logic [63:0]   dev_calc;
    logic [63:0]   avg_calc;
    logic [63:0]   spread_calc;
    logic [CW-1:0] hist_inc;
    logic [63:0]   hist_w;
    logic [CW-1:0] outst;
    logic [63:0]   outst_w;

    // Divider hookup.
    logic          div_start;
    logic [63:0]   div_dividend;
    logic [32:0]   div_divisor;
    logic [6:0]    div_steps;
    logic          div_done;
    logic [63:0]   div_quotient;
    logic [37:0]   gap_num;

    sld_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        eff_rate  = (cfg.start_rate == 24'd0) ? 32'd1 : 32'(cfg.start_rate);
        eff_burst = (cfg.burst_size == 8'd0) ? 8'd1 : cfg.burst_size;
        eff_ms    = (cfg.backlog_ms == 16'd0) ? sld_pkg::DEFAULT_MS : cfg.backlog_ms;

        gap_num      = 38'(sld_pkg::NS_PER_SEC) * 38'(eff_burst);
        div_start    = cmd.div_gap || cmd.div_ema;
        if (cmd.div_ema)
        begin
            div_dividend = 64'({backlog_reg, 1'b0}) + 64'(prod_reg);
            div_divisor  = 33'(rate_reg) + 33'd1;
            div_steps    = sld_pkg::EMA_STEPS;
        end
        else
        begin
            // The gap numerator is 38 bits wide, so only 38 steps are run.
            div_dividend = {gap_num, 26'd0};
            div_divisor  = 33'(rate_reg);
            div_steps    = sld_pkg::GAP_STEPS;
        end

        sent_inc  = sent_reg + CW'(burst_reg);
        diff      = sent_inc - recv_reg;
        diff_w    = 64'(diff);
        if (diff[CW-1])
            backlog = 31'd0;
        else if (diff_w > sld_pkg::MAX31)
            backlog = 31'h7FFF_FFFF;
        else
            backlog = diff_w[30:0];
        prod_calc = 63'(rate_reg - 32'd1) * 63'(ema_reg);

        ema_lhs   = 48'(ema_reg) * 48'(sld_pkg::EMA_SCALE);
        rate_rhs  = 48'(rate_reg) * 48'(eff_ms);
        sending   = ema_lhs < rate_rhs;
        now_w     = 64'(now_reg);
        next_send = last_sent_reg + 64'(gap_reg);
        next_gate = now_w + 64'(gap_reg);

        step_end  = (next_reg >= step_begin_reg)
                 && ((next_reg - step_begin_reg) >= 64'(cfg.step_duration));
        rate_sum  = 33'(rate_reg) + 33'(cfg.rate_increment);
        rate_new  = rate_sum[32] ? 32'hFFFF_FFFF : rate_sum[31:0];
        drain     = step_end && (cfg.rate_ceiling != 32'd0) && (rate_new > cfg.rate_ceiling);
        state_after = drain ? sld_pkg::GEN_DRAINING : run_state_reg;

        lat_calc  = (now_reg > rq_reg) ? (now_reg - rq_reg) : 63'd0;
        bidx_calc = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (lat_calc >= 63'(sld_pkg::DECADE_LIMIT[i]))
                bidx_calc = bidx_calc + 3'd1;
        end

        lat_w    = 64'(lat_reg);
        dev_calc = (rtt_avg_reg < lat_w) ? (lat_w - rtt_avg_reg) : (rtt_avg_reg - lat_w);
        avg_calc = (lat_w >> 3) + ((rtt_avg_reg >> 3) * 64'd7)
                 + ((64'(lat_w[2:0]) + 64'(rtt_avg_reg[2:0]) * 64'd7) >> 3);
        spread_calc = ((rtt_dev_reg >> 2) * 64'd3) + (dev_reg >> 2)
                    + ((64'(rtt_dev_reg[1:0]) * 64'd3 + 64'(dev_reg[1:0])) >> 2);
        hist_inc = hist_reg[bidx_reg] + CW'(1);
        hist_w   = 64'(hist_inc);
        outst    = sent_reg - recv_reg;
        outst_w  = 64'(outst);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_state_reg  <= sld_pkg::GEN_INIT;
            rate_reg       <= 32'd1;
            gap_reg        <= 40'(sld_pkg::NS_PER_SEC);
            burst_reg      <= 8'd1;
            step_begin_reg <= 64'd0;
            last_sent_reg  <= 64'd0;
            sent_reg       <= '0;
            recv_reg       <= '0;
            peak_reg       <= 31'd0;
            ema_reg        <= 31'd0;
            rtt_avg_reg    <= 64'd0;
            rtt_dev_reg    <= 64'd0;
            for (int i = 0; i < 8; i++)
            begin
                hist_reg[i] <= '0;
            end
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start_init)
            begin
                rate_reg       <= eff_rate;
                burst_reg      <= eff_burst;
                step_begin_reg <= now_w;
            end
            if (cmd.gap_store)
                gap_reg <= {2'b00, div_quotient[37:0]};
            if (cmd.tick_a)
            begin
                sent_reg <= sent_inc;
                if (backlog > peak_reg)
                    peak_reg <= backlog;
            end
            if (cmd.ema_store)
                ema_reg <= div_quotient[30:0];
            if (cmd.tick_b)
            begin
                run_state_reg <= sending ? sld_pkg::GEN_SENDING : sld_pkg::GEN_GATED;
                burst_reg     <= sending ? eff_burst : 8'd1;
            end
            if (cmd.tick_c)
            begin
                run_state_reg <= state_after;
                last_sent_reg <= now_w;
                if (step_end)
                begin
                    step_begin_reg <= next_reg;
                    rate_reg       <= rate_new;
                end
            end
            if (cmd.reply_b)
            begin
                rtt_avg_reg         <= avg_calc;
                hist_reg[bidx_reg]  <= hist_inc;
                recv_reg            <= recv_reg + CW'(1);
            end
            if (cmd.reply_c)
                rtt_dev_reg <= spread_calc;

            if (cmd.emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg  <= req.req_type;
            now_reg   <= req.now;
            rq_reg    <= req.sent_time;
            cnt_reg   <= 8'd0;
            armed_reg <= 1'b0;
            delay_reg <= 38'd0;
            done_reg  <= 1'b0;
            bidx_reg  <= 3'd0;
            btot_reg  <= 32'd0;
        end
        if (cmd.tick_a)
        begin
            backlog_reg <= backlog;
            prod_reg    <= prod_calc;
        end
        if (cmd.tick_b)
        begin
            if (sending)
            begin
                next_reg <= next_send;
                dly_reg  <= (next_send < now_w) ? 64'd0 : (next_send - now_w);
            end
            else
            begin
                next_reg <= next_gate;
                dly_reg  <= 64'd0;
            end
        end
        if (cmd.tick_c)
        begin
            cnt_reg   <= burst_reg;
            armed_reg <= (state_after == sld_pkg::GEN_SENDING);
            if (state_after != sld_pkg::GEN_SENDING)
                delay_reg <= 38'd0;
            else if (dly_reg > 64'(sld_pkg::DELAY_MAX))
                delay_reg <= sld_pkg::DELAY_MAX;
            else
                delay_reg <= dly_reg[37:0];
        end
        if (cmd.reply_a)
        begin
            lat_reg  <= lat_calc;
            bidx_reg <= bidx_calc;
        end
        if (cmd.reply_b)
        begin
            dev_reg  <= dev_calc;
            btot_reg <= hist_w[31:0];
        end
        if (cmd.finish)
            done_reg <= 1'b1;
        if (cmd.emit)
        begin
            rsp_reg.send_count   <= cnt_reg;
            rsp_reg.timer_armed  <= armed_reg;
            rsp_reg.timer_delay  <= delay_reg;
            rsp_reg.gen_state    <= run_state_reg;
            rsp_reg.done_res     <= done_reg;
            rsp_reg.backlog_ema  <= ema_reg;
            rsp_reg.peak_backlog <= peak_reg;
            rsp_reg.rtt_avg      <= rtt_avg_reg[62:0];
            rsp_reg.rtt_dev      <= rtt_dev_reg[62:0];
            rsp_reg.bucket_index <= bidx_reg;
            rsp_reg.bucket_total <= btot_reg;
            rsp_reg.outstanding  <= outst_w[31:0];
        end
    end

    assign sts.req_type  = type_reg;
    assign sts.run_state = run_state_reg;
    assign sts.div_done  = div_done;
    assign sts.step_end  = step_end;
    assign sts.drained   = recv_reg >= sent_reg;
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/sld_ctrl.sv]
// Sequencing state machine for the stepped load generator.
// Depends on sld_pkg for the command and status structs and the state codes.
module sld_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          busy,
    input  sld_pkg::sts_t sts,
    output sld_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_GAP   = 4'd3;
    localparam logic [3:0] S_GAPW  = 4'd4;
    localparam logic [3:0] S_TA    = 4'd5;
    localparam logic [3:0] S_EMA   = 4'd6;
    localparam logic [3:0] S_EMAW  = 4'd7;
    localparam logic [3:0] S_TB    = 4'd8;
    localparam logic [3:0] S_TC    = 4'd9;
    localparam logic [3:0] S_RA    = 4'd10;
    localparam logic [3:0] S_RB    = 4'd11;
    localparam logic [3:0] S_RC    = 4'd12;
    localparam logic [3:0] S_RD    = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       from_start_reg;
    logic       from_start_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        from_start_next = from_start_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.req_type)
                    sld_pkg::REQ_START: state_next = S_START;
                    sld_pkg::REQ_TIMER:
                        state_next = (sts.run_state == sld_pkg::GEN_SENDING) ? S_TA : S_OUT;
                    sld_pkg::REQ_REPLY: state_next = S_RA;
                    default:            state_next = S_OUT;
                endcase
            end
            S_START:
            begin
                cmd.start_init  = 1'b1;
                from_start_next = 1'b1;
                state_next      = S_GAP;
            end
            S_GAP:
            begin
                cmd.div_gap = 1'b1;
                state_next  = S_GAPW;
            end
            S_GAPW:
            begin
                if (sts.div_done)
                begin
                    cmd.gap_store = 1'b1;
                    state_next    = from_start_reg ? S_TA : S_OUT;
                end
            end
            S_TA:
            begin
                cmd.tick_a = 1'b1;
                state_next = S_EMA;
            end
            S_EMA:
            begin
                cmd.div_ema = 1'b1;
                state_next  = S_EMAW;
            end
            S_EMAW:
            begin
                if (sts.div_done)
                begin
                    cmd.ema_store = 1'b1;
                    state_next    = S_TB;
                end
            end
            S_TB:
            begin
                cmd.tick_b = 1'b1;
                state_next = S_TC;
            end
            S_TC:
            begin
                // The gap is recomputed from the raised rate at the end of a step.
                cmd.tick_c      = 1'b1;
                from_start_next = 1'b0;
                state_next      = sts.step_end ? S_GAP : S_OUT;
            end
            S_RA:
            begin
                cmd.reply_a = 1'b1;
                state_next  = S_RB;
            end
            S_RB:
            begin
                cmd.reply_b = 1'b1;
                state_next  = S_RC;
            end
            S_RC:
            begin
                cmd.reply_c = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                if (sts.run_state == sld_pkg::GEN_GATED)
                    state_next = S_TA;
                else
                begin
                    if (sts.run_state == sld_pkg::GEN_DRAINING && sts.drained)
                        cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            from_start_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            from_start_reg <= from_start_next;
        end
    end

endmodule

[rtl/stepped_load_generator.sv]
// Stepped-rate packet load generator with round trip statistics, top level.
// A timer tick passes dispatch, the tick states and output, with the 64-step divider run for
// the moving average between them; a step end adds the gap division, a start adds its setup
// and a gap division. A reply runs its states, plus a tick when gated. One item at a time.
// Reset clears all generator state and loads the registers with their defaults at once.
module stepped_load_generator #(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sld_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sld_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    sld_pkg::cfg_t cfg;
    sld_pkg::cmd_t cmd;
    sld_pkg::sts_t sts;
    logic          busy;

    assign req_stall = busy;

    sld_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sld_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .busy      (busy),
        .sts       (sts),
        .cmd       (cmd)
    );

    sld_datapath #(
        .CW (COUNTER_WIDTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the stepped load generator.
// Depends on rtl/sld_pkg.sv and rtl/stepped_load_generator.sv; predicts every result in-bench.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0]  REQ_NOP    = 2'd3;
    localparam logic [63:0] M32        = 64'hFFFF_FFFF;
    localparam logic [63:0] M63        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] GAP_UNIT   = 64'd1000000000;
    localparam int          IDLE_LIMIT = 20000;
    localparam logic [63:0] DECADE [7] = '{64'd1000, 64'd10000, 64'd100000, 64'd1000000,
                                           64'd10000000, 64'd100000000, 64'd1000000000};

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    sld_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    sld_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [5:0]    paddr;
    logic [63:0]   pwdata;
    logic [63:0]   prdata;
    logic          pready;

    stepped_load_generator dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register copies and generator state of the predictor.
    logic [63:0] c_rate0, c_ms, c_burst, c_step, c_inc, c_ceil;
    logic [1:0]  g_state;
    logic [63:0] g_rate, g_gap, g_burst, g_step_begin, g_last_sent;
    logic [63:0] g_sent, g_recv, g_peak, g_ema, g_rtt, g_dev;
    logic [63:0] g_hist [8];
    logic        tick_armed;
    logic [63:0] tick_delay;

    sld_pkg::rsp_t expected_rsp [$];
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          done_seen;
    int          drain_seen;
    int          gated_seen;
    int          idle_cycles;
    int          hold_cycles;
    bit          fast_mode;
    logic [63:0] clock_ns;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] burst_eff();
        return (c_burst != 0) ? c_burst : 64'd1;
    endfunction

    function automatic logic [63:0] run_tick(input logic [63:0] now);
        logic [63:0] diff, backlog, next, dly;
        dly = 0;
        g_sent = (g_sent + g_burst) & M32;
        diff = (g_sent - g_recv) & M32;
        backlog = diff[31] ? 64'd0 : diff;
        if (backlog > g_peak)
            g_peak = backlog;
        g_ema = (2 * backlog + (g_rate - 1) * g_ema) / (g_rate + 1);
        if (g_ema * 1000 < g_rate * ((c_ms != 0) ? c_ms : 64'd1000))
        begin
            g_state = sld_pkg::GEN_SENDING;
            g_burst = burst_eff();
            next = g_last_sent + g_gap;
            dly = (next < now) ? 64'd0 : next - now;
        end
        else
        begin
            g_state = sld_pkg::GEN_GATED;
            g_burst = 1;
            next = now + g_gap;
        end
        if (next >= g_step_begin && next - g_step_begin >= c_step)
        begin
            g_step_begin = next;
            g_rate = (g_rate + c_inc > M32) ? M32 : g_rate + c_inc;
            g_gap = GAP_UNIT * burst_eff() / g_rate;
            if (c_ceil != 0 && g_rate > c_ceil)
                g_state = sld_pkg::GEN_DRAINING;
        end
        g_last_sent = now;
        tick_armed = (g_state == sld_pkg::GEN_SENDING);
        tick_delay = !tick_armed ? 64'd0 :
                     (dly > sld_pkg::DELAY_MAX) ? {26'd0, sld_pkg::DELAY_MAX} : dly;
        return g_burst;
    endfunction

    function automatic sld_pkg::rsp_t predict_status(input sld_pkg::req_t r);
        sld_pkg::rsp_t o;
        logic [63:0]   now, lat, d, v, a, cnt;
        int            i;
        now = {1'b0, r.now};
        cnt = 0;
        tick_armed = 0;
        tick_delay = 0;
        o = '0;
        if (r.req_type == sld_pkg::REQ_START)
        begin
            g_rate = (c_rate0 != 0) ? c_rate0 : 64'd1;
            g_burst = burst_eff();
            g_gap = GAP_UNIT * g_burst / g_rate;
            g_step_begin = now;
            cnt = run_tick(now);
        end
        else if (r.req_type == sld_pkg::REQ_TIMER)
        begin
            if (g_state == sld_pkg::GEN_SENDING)
                cnt = run_tick(now);
        end
        else if (r.req_type == sld_pkg::REQ_REPLY)
        begin
            lat = (now > {1'b0, r.sent_time}) ? now - {1'b0, r.sent_time} : 64'd0;
            d = (g_rtt < lat) ? lat - g_rtt : g_rtt - lat;
            v = g_dev;
            a = g_rtt;
            g_dev = 3 * (v >> 2) + (d >> 2) + (3 * (v & 3) + (d & 3)) / 4;
            g_rtt = (lat >> 3) + 7 * (a >> 3) + ((lat & 7) + 7 * (a & 7)) / 8;
            i = 0;
            while (i < 7 && lat >= DECADE[i])
                i++;
            g_hist[i] = (g_hist[i] + 1) & M32;
            o.bucket_index = i[2:0];
            o.bucket_total = g_hist[i][31:0];
            g_recv = (g_recv + 1) & M32;
            if (g_state == sld_pkg::GEN_GATED)
                cnt = run_tick(now);
            else if (g_state == sld_pkg::GEN_DRAINING && g_recv >= g_sent)
                o.done_res = 1'b1;
        end
        o.send_count   = cnt[7:0];
        o.timer_armed  = tick_armed;
        o.timer_delay  = tick_delay[37:0];
        o.gen_state    = g_state;
        o.backlog_ema  = g_ema[30:0];
        o.peak_backlog = g_peak[30:0];
        o.rtt_avg      = g_rtt[62:0];
        o.rtt_dev      = g_dev[62:0];
        o.outstanding  = g_sent[31:0] - g_recv[31:0];
        return o;
    endfunction

    task automatic reset_model();
        c_rate0 = 1; c_ms = 1000; c_burst = 1; c_step = GAP_UNIT; c_inc = 0; c_ceil = 0;
        g_state = sld_pkg::GEN_INIT; g_rate = 1; g_gap = GAP_UNIT; g_burst = 1;
        g_step_begin = 0; g_last_sent = 0; g_sent = 0; g_recv = 0; g_peak = 0;
        g_ema = 0; g_rtt = 0; g_dev = 0;
        for (int i = 0; i < 8; i++)
            g_hist[i] = 0;
    endtask

    // Writes one register: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sld_pkg::REG_START_RATE:     c_rate0 = value & 64'hFF_FFFF;
            sld_pkg::REG_BACKLOG_MS:     c_ms = value & 64'hFFFF;
            sld_pkg::REG_BURST_SIZE:     c_burst = value & 64'hFF;
            sld_pkg::REG_STEP_DURATION:  c_step = value & M63;
            sld_pkg::REG_RATE_INCREMENT: c_inc = value & 64'hFF_FFFF;
            sld_pkg::REG_RATE_CEILING:   c_ceil = value & M32;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] r0, input logic [63:0] ms,
                             input logic [63:0] b, input logic [63:0] st,
                             input logic [63:0] inc, input logic [63:0] ceil);
        write_reg(sld_pkg::REG_START_RATE, r0);
        write_reg(sld_pkg::REG_BACKLOG_MS, ms);
        write_reg(sld_pkg::REG_BURST_SIZE, b);
        write_reg(sld_pkg::REG_STEP_DURATION, st);
        write_reg(sld_pkg::REG_RATE_INCREMENT, inc);
        write_reg(sld_pkg::REG_RATE_CEILING, ceil);
    endtask

    // Offers one item and holds it until accepted; valid stays high across back-to-back items.
    task automatic send_item(input logic [1:0] kind, input logic [63:0] now,
                             input logic [63:0] rq, input bit gaps);
        sld_pkg::req_t r;
        int            gap;
        r.req_type = kind;
        r.now = now[62:0];
        r.sent_time = rq[62:0];
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp.push_back(predict_status(r));
        items_sent++;
        gap = 0;
        if (gaps && !fast_mode)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_latency();
        logic [63:0] span;
        int          k;
        k = $urandom_range(0, 10);
        span = 1;
        repeat (k) span = span * 10;
        return {$urandom, $urandom} % (span + 1);
    endfunction

    task automatic send_reply_at(input logic [63:0] lat);
        clock_ns = clock_ns + 64'($urandom_range(0, 5000));
        send_item(sld_pkg::REQ_REPLY, clock_ns, (clock_ns > lat) ? clock_ns - lat : 64'd0, 1'b1);
    endtask

    task automatic test_directed();
        logic [63:0] lat;
        clock_ns = 1000;
        send_item(sld_pkg::REQ_TIMER, clock_ns, 0, 1'b1);
        send_item(REQ_NOP, M63, M63, 1'b1);
        send_item(sld_pkg::REQ_REPLY, 0, M63, 1'b1);
        send_item(sld_pkg::REQ_START, clock_ns, 0, 1'b1);
        send_item(sld_pkg::REQ_TIMER, clock_ns + 500, 0, 1'b1);
        lat = 999;
        for (int i = 0; i < 8; i++)
        begin
            send_reply_at(lat);
            send_reply_at(lat + 1);
            lat = lat * 10 + 9;
        end
        send_item(sld_pkg::REQ_START, clock_ns + 10, 0, 1'b1);
        send_item(sld_pkg::REQ_TIMER, M63, 0, 1'b1);
        send_item(sld_pkg::REQ_REPLY, M63, 0, 1'b1);
        wait_quiet();
    endtask

    task automatic test_draining();
        clock_ns = 5000;
        write_all(10, 1000, 4, 0, 10, 15);
        send_item(sld_pkg::REQ_START, clock_ns, 0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_reply_at(pick_latency());
        wait_quiet();
    endtask

    task automatic test_register_extremes();
        write_all(64'hFF_FFFF, 64'hFFFF, 64'hFF, M63, 64'hFF_FFFF, M32);
        send_item(sld_pkg::REQ_START, 7, 0, 1'b1);
        send_item(sld_pkg::REQ_TIMER, 100, 0, 1'b1);
        send_item(sld_pkg::REQ_REPLY, 200, 1, 1'b1);
        wait_quiet();
        write_all(0, 0, 0, 0, 0, 0);
        send_item(sld_pkg::REQ_START, 300, 0, 1'b1);
        send_item(sld_pkg::REQ_TIMER, 400, 0, 1'b1);
        send_item(sld_pkg::REQ_REPLY, 500, 2, 1'b1);
        wait_quiet();
    endtask

    // A phase of well-formed traffic with random content and some noise.
    task automatic test_random_traffic(input int count);
        int          pick;
        logic [63:0] step;
        send_item(sld_pkg::REQ_START, clock_ns, 0, 1'b1);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 50)
                fast_mode = !fast_mode;
            pick = $urandom_range(0, 99);
            step = (pick < 5) ? {$urandom, $urandom} & M63 : 64'($urandom_range(0, 3000000));
            clock_ns = (clock_ns + step) & M63;
            if (pick < 4)
                send_item(sld_pkg::REQ_START, clock_ns, 0, 1'b1);
            else if (pick < 50)
                send_item(sld_pkg::REQ_TIMER, clock_ns, 0, 1'b1);
            else if (pick < 94)
                send_item(sld_pkg::REQ_REPLY, clock_ns,
                          (clock_ns > pick_latency()) ? clock_ns - pick_latency() : 64'd0, 1'b1);
            else
                send_item(2'($urandom_range(0, 3)), {$urandom, $urandom},
                          {$urandom, $urandom}, 1'b1);
        end
        wait_quiet();
    endtask

    task automatic test_back_pressure();
        hold_cycles = 400;
        for (int n = 0; n < 6; n++)
        begin
            clock_ns = clock_ns + 1000;
            send_item((n == 0) ? sld_pkg::REQ_START : sld_pkg::REQ_REPLY, clock_ns,
                      clock_ns - 300, 1'b0);
        end
        wait_quiet();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", rsp);
            end
            else
            begin
                if (rsp !== expected_rsp[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", expected_rsp[0], rsp);
                end
                if (rsp.done_res)
                    done_seen++;
                if (rsp.gen_state == sld_pkg::GEN_DRAINING)
                    drain_seen++;
                if (rsp.gen_state == sld_pkg::GEN_GATED)
                    gated_seen++;
                void'(expected_rsp.pop_front());
            end
        end
    end

    // Receiver stall: random gaps, quiet stretches and the occasional long hold-off.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles--;
            end
            else if (fast_mode)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 3) == 0)
                             || ($urandom_range(0, 49) == 0 && rsp_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_cycles = 0;
        fast_mode = 1'b0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        done_seen = 0;
        drain_seen = 0;
        gated_seen = 0;
        idle_cycles = 0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_draining();
        test_back_pressure();
        write_all(1000, 1, 8, 2000000, 500, 0);
        test_random_traffic(350);
        write_all(50, 20, 1, 5000000, 100, 3000);
        test_random_traffic(350);
        write_all(100000, 1000, 32, 0, 20000, 400000);
        test_random_traffic(350);
        write_all(64'hFF_FFFF, 64'hFFFF, 64'hFF, 10000000, 64'hFF_FFFF, 0);
        test_random_traffic(350);
        test_back_pressure();

        repeat (200) @(posedge clk);
        $display("%0d items sent, %0d results checked; %0d gated, %0d draining, %0d done.",
                 items_sent, results_seen, gated_seen, drain_seen, done_seen);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
